### hw/rtl/awfs_pkg.sv
// Shared types, register map and reset values of the adaptive weight filter.
package awfs_pkg;

    // Configuration port geometry
    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] RegRateReload    = 3'd0;
    localparam logic [2:0] RegShiftMax      = 3'd1;
    localparam logic [2:0] RegLeaveLimit    = 3'd2;
    localparam logic [2:0] RegUnstableLimit = 3'd3;
    localparam logic [2:0] RegEnterDelay    = 3'd4;
    localparam logic [2:0] RegSettleReload  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [15:0] RstRateReload    = 16'd10;
    localparam logic [3:0]  RstShiftMax      = 4'd8;
    localparam logic [6:0]  RstLeaveLimit    = 7'd20;
    localparam logic [6:0]  RstUnstableLimit = 7'd5;
    localparam logic [15:0] RstEnterDelay    = 16'd50;
    localparam logic [15:0] RstSettleReload  = 16'd200;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [15:0] rate_reload;
        logic [3:0]  shift_max;
        logic [6:0]  leave_limit;
        logic [6:0]  unstable_limit;
        logic [15:0] enter_delay;
        logic [15:0] settle_reload;
    } t_cfg;

endpackage

### hw/rtl/awfs_cfg.sv
// APB-style configuration register file of the adaptive weight filter.
module awfs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [awfs_pkg::AddrW-1:0]  paddr,
    input  logic [awfs_pkg::DataW-1:0]  pwdata,
    output logic [awfs_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output awfs_pkg::t_cfg              o_cfg
);

    awfs_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Write the addressed register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_reload    <= awfs_pkg::RstRateReload;
            r_cfg.shift_max      <= awfs_pkg::RstShiftMax;
            r_cfg.leave_limit    <= awfs_pkg::RstLeaveLimit;
            r_cfg.unstable_limit <= awfs_pkg::RstUnstableLimit;
            r_cfg.enter_delay    <= awfs_pkg::RstEnterDelay;
            r_cfg.settle_reload  <= awfs_pkg::RstSettleReload;
        end else if (wr_en) begin
            unique case (reg_idx)
                awfs_pkg::RegRateReload:    r_cfg.rate_reload    <= pwdata[15:0];
                awfs_pkg::RegShiftMax:      r_cfg.shift_max      <= pwdata[3:0];
                awfs_pkg::RegLeaveLimit:    r_cfg.leave_limit    <= pwdata[6:0];
                awfs_pkg::RegUnstableLimit: r_cfg.unstable_limit <= pwdata[6:0];
                awfs_pkg::RegEnterDelay:    r_cfg.enter_delay    <= pwdata[15:0];
                awfs_pkg::RegSettleReload:  r_cfg.settle_reload  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            awfs_pkg::RegRateReload:    prdata = {16'd0, r_cfg.rate_reload};
            awfs_pkg::RegShiftMax:      prdata = {28'd0, r_cfg.shift_max};
            awfs_pkg::RegLeaveLimit:    prdata = {25'd0, r_cfg.leave_limit};
            awfs_pkg::RegUnstableLimit: prdata = {25'd0, r_cfg.unstable_limit};
            awfs_pkg::RegEnterDelay:    prdata = {16'd0, r_cfg.enter_delay};
            awfs_pkg::RegSettleReload:  prdata = {16'd0, r_cfg.settle_reload};
            default:                    prdata = '0;
        endcase
    end

endmodule

### hw/rtl/adaptive_weight_filter_with_stability.sv
// Top level of the adaptive weight filter: input register, filter update, result register.
//
//   channel | direction | handshake                      | payload
//   in      | input     | i_in_valid / o_in_stall        | i_action, i_sample
//   out     | output    | o_out_valid / i_out_stall      | o_filtered, o_is_stable, o_direction,
//           |           |                                | o_shift_now, o_settle_left
//   cfg     | input     | psel / penable / pwrite/pready | paddr, pwdata, prdata
//
// One transaction per cycle sustained while the output does not stall.
// The filter step, ramp counter and timer update for one transaction is combinational
// logic between the input and result registers (a variable shift and three chained adds).
// Reset (i_rst_n low, synchronous) clears all filter state and loads the register defaults.
// A stall on the output holds the result register and backs up into the input register;
// the input side stalls only when both hold a transaction.
module adaptive_weight_filter_with_stability (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [15:0]                 i_sample,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [23:0]                 o_filtered,
    output logic                        o_is_stable,
    output logic signed [1:0]           o_direction,
    output logic [3:0]                  o_shift_now,
    output logic [15:0]                 o_settle_left,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [awfs_pkg::AddrW-1:0]  paddr,
    input  logic [awfs_pkg::DataW-1:0]  pwdata,
    output logic [awfs_pkg::DataW-1:0]  prdata,
    output logic                        pready
);

    localparam logic signed [24:0] StepPos = 25'sd256;
    localparam logic signed [24:0] StepNeg = -25'sd256;
    localparam logic signed [24:0] NearHi  = 25'sd255;

    awfs_pkg::t_cfg cfg;

    // Input register
    logic        r_in_valid;
    logic        r_in_action;
    logic [15:0] r_in_sample;

    // Filter state
    logic [23:0] r_acc,      n_acc;
    logic [23:0] r_ref,      n_ref;
    logic [3:0]  r_shift,    n_shift;
    logic [7:0]  r_ramp,     n_ramp;
    logic        r_stable,   n_stable;
    logic [15:0] r_rate_tmr, n_rate_tmr;
    logic [15:0] r_settle,   n_settle;
    logic [15:0] r_enter,    n_enter;

    // Result register
    logic              r_out_valid;
    logic [23:0]       r_out_filtered;
    logic              r_out_stable;
    logic signed [1:0] r_out_dir;
    logic [3:0]        r_out_shift;
    logic [15:0]       r_out_settle;

    // Datapath intermediates
    logic              out_free;
    logic              fire;
    logic              in_accept;
    logic signed [24:0] diff;
    logic signed [24:0] step;
    logic signed [24:0] ref_diff;
    logic              dir_pos;
    logic              dir_neg;
    logic signed [1:0] n_dir;
    logic              ref_neg;
    logic              ref_near;
    logic [7:0]        ramp_tmp;

    awfs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // True when the signed ramp count lies outside [-limit, limit]
    function automatic logic ramp_beyond(input logic [7:0] ramp, input logic [6:0] limit);
        logic signed [8:0] rs;
        logic signed [8:0] ls;
        rs = signed'({ramp[7], ramp});
        ls = signed'({2'b00, limit});
        return (rs > ls) || (rs < -ls);
    endfunction

    // Handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Filter step and stability update for the held transaction
    always_comb begin
        n_acc      = r_acc;
        n_ref      = r_ref;
        n_shift    = r_shift;
        n_ramp     = r_ramp;
        n_stable   = r_stable;
        n_rate_tmr = r_rate_tmr;
        n_settle   = r_settle;
        n_enter    = r_enter;
        n_dir      = 2'sd0;
        diff       = '0;
        step       = '0;
        ref_diff   = '0;
        dir_pos    = 1'b0;
        dir_neg    = 1'b0;
        ref_neg    = 1'b0;
        ref_near   = 1'b0;
        ramp_tmp   = '0;

        if (r_in_action) begin
            // Tick: count each timer down to zero
            if (r_rate_tmr != 16'd0) n_rate_tmr = r_rate_tmr - 16'd1;
            if (r_settle   != 16'd0) n_settle   = r_settle   - 16'd1;
            if (r_enter    != 16'd0) n_enter    = r_enter    - 16'd1;
        end else begin
            // Grow the shift when the rate timer has run out
            if (r_rate_tmr == 16'd0) begin
                n_rate_tmr = cfg.rate_reload;
                if (r_shift < cfg.shift_max) n_shift = r_shift + 4'd1;
            end

            // Move the accumulator toward sample * 256
            diff    = signed'({1'b0, r_in_sample, 8'd0}) - signed'({1'b0, r_acc});
            step    = diff >>> n_shift;
            n_acc   = r_acc + step[23:0];
            dir_pos = step >= StepPos;
            dir_neg = step < StepNeg;
            if (dir_pos) n_dir = 2'sd1;
            if (dir_neg) n_dir = -2'sd1;
            if (dir_pos || dir_neg) n_settle = cfg.settle_reload;

            if (r_stable) begin
                // Track drift away from the stable reference
                ref_diff = signed'({1'b0, n_acc}) - signed'({1'b0, r_ref});
                ref_neg  = ref_diff[24];
                ref_near = ref_neg ? (ref_diff >= StepNeg) : (ref_diff <= NearHi);
                ramp_tmp = ref_neg ? (r_ramp - 8'd1) : (r_ramp + 8'd1);
                n_ramp   = ramp_tmp;
                if (ref_near || (ref_neg != ramp_tmp[7])) begin
                    n_ramp = 8'd0;
                end else if (ramp_beyond(ramp_tmp, cfg.leave_limit)) begin
                    n_ramp     = 8'd0;
                    n_shift    = 4'd0;
                    n_stable   = 1'b0;
                    n_rate_tmr = cfg.rate_reload;
                    n_enter    = cfg.enter_delay;
                end
            end else begin
                n_settle = cfg.settle_reload;
                if (dir_pos || dir_neg) begin
                    // Count a run of same-direction steps
                    ramp_tmp = dir_pos ? (r_ramp + 8'd1) : (r_ramp - 8'd1);
                    n_enter  = cfg.enter_delay;
                    if (ramp_tmp[7] != dir_neg) ramp_tmp = 8'd0;
                    n_ramp = ramp_tmp;
                    if (ramp_beyond(ramp_tmp, cfg.unstable_limit)) begin
                        n_ramp     = 8'd0;
                        n_shift    = 4'd0;
                        n_rate_tmr = cfg.rate_reload;
                    end
                end else begin
                    // Quiet step: declare stable once the enter timer is done
                    n_ramp = 8'd0;
                    if (r_enter == 16'd0) begin
                        n_stable = 1'b1;
                        n_ref    = n_acc;
                    end
                end
            end
        end
    end

    // Control: input and result valid flags, filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
            r_ref       <= '0;
            r_shift     <= '0;
            r_ramp      <= '0;
            r_stable    <= 1'b0;
            r_rate_tmr  <= '0;
            r_settle    <= '0;
            r_enter     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_acc      <= n_acc;
                r_ref      <= n_ref;
                r_shift    <= n_shift;
                r_ramp     <= n_ramp;
                r_stable   <= n_stable;
                r_rate_tmr <= n_rate_tmr;
                r_settle   <= n_settle;
                r_enter    <= n_enter;
            end
        end
    end

    // Payload: capture the input transaction and the result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_action <= i_action;
            r_in_sample <= i_sample;
        end
        if (fire) begin
            r_out_filtered <= n_acc;
            r_out_stable   <= n_stable;
            r_out_dir      <= n_dir;
            r_out_shift    <= n_shift;
            r_out_settle   <= n_settle;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_filtered    = r_out_filtered;
    assign o_is_stable   = r_out_stable;
    assign o_direction   = r_out_dir;
    assign o_shift_now   = r_out_shift;
    assign o_settle_left = r_out_settle;

`ifndef SYNTHESIS
    // Entering the stable state always clears the ramp counter
    a_stable_entry_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_stable) |-> (r_ramp == 8'd0))
        else $error("ramp count not cleared on entering stable");

    // A significant step reloads the settle countdown
    a_dir_reloads_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_direction != 2'sd0)) |-> (o_settle_left == cfg.settle_reload))
        else $error("settle countdown not reloaded on significant step");

    // Input stalls only while a transaction is held
    a_stall_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with no transaction held");
`endif

endmodule

### tb/sv/awfs_tb_pkg.sv
// Transaction types shared by the stimulus and the checker of the adaptive weight filter bench.
package awfs_tb_pkg;

    // Kind of input transaction
    typedef enum logic {
        ActSample = 1'b0,
        ActTick   = 1'b1
    } action_e;

    // One result transaction, in port order
    typedef struct packed {
        logic [23:0] filtered;
        logic        is_stable;
        logic [1:0]  direction;
        logic [3:0]  shift_now;
        logic [15:0] settle_left;
    } weigh_res_t;

endpackage

### tb/sv/awfs_checker.sv
// Checker of the adaptive weight filter: mirrors the filter state, predicts and compares results.
module awfs_checker
    import awfs_pkg::*;
    import awfs_tb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                i_action,
    input  logic [15:0]         i_sample,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [23:0]         o_filtered,
    input  logic                o_is_stable,
    input  logic signed [1:0]   o_direction,
    input  logic [3:0]          o_shift_now,
    input  logic [15:0]         o_settle_left,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    input  logic [DataW-1:0]    prdata,
    input  logic                pready,
    output int                  n_fail,
    output int                  n_pending,
    output int                  n_results,
    output int                  n_stable_out,
    output int                  n_moves
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirrored configuration and filter state
    t_cfg        cfg;
    logic [31:0] acc_q;
    logic [31:0] ref_q;
    logic [3:0]  shf_q;
    logic [7:0]  ramp_q;
    logic        stb_q;
    logic [15:0] rate_t;
    logic [15:0] settle_t;
    logic [15:0] enter_t;

    weigh_res_t  expected_q[$];
    int          fail_cnt = 0;
    int          results_cnt = 0;
    int          stable_cnt = 0;
    int          move_cnt = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_cnt++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    task automatic clear_filter_model();
        cfg.rate_reload    = RstRateReload;
        cfg.shift_max      = RstShiftMax;
        cfg.leave_limit    = RstLeaveLimit;
        cfg.unstable_limit = RstUnstableLimit;
        cfg.enter_delay    = RstEnterDelay;
        cfg.settle_reload  = RstSettleReload;
        acc_q    = '0;
        ref_q    = '0;
        shf_q    = '0;
        ramp_q   = '0;
        stb_q    = 1'b0;
        rate_t   = '0;
        settle_t = '0;
        enter_t  = '0;
    endtask

    function automatic logic [31:0] cfg_readback(input logic [2:0] idx);
        case (idx)
            RegRateReload:    return {16'b0, cfg.rate_reload};
            RegShiftMax:      return {28'b0, cfg.shift_max};
            RegLeaveLimit:    return {25'b0, cfg.leave_limit};
            RegUnstableLimit: return {25'b0, cfg.unstable_limit};
            RegEnterDelay:    return {16'b0, cfg.enter_delay};
            RegSettleReload:  return {16'b0, cfg.settle_reload};
            default:          return '0;
        endcase
    endfunction

    // Advance the mirrored filter by one transaction and form its result
    task automatic predict_weigh(input action_e act, input logic [15:0] smp,
                                 output weigh_res_t res);
        logic signed [33:0] diff;
        logic signed [33:0] step;
        logic signed [33:0] offset_v;
        logic               neg;
        logic               near;
        int                 move;
        int                 ramp_v;
        int                 leave_v;
        int                 unst_v;
        move    = 0;
        leave_v = cfg.leave_limit;
        unst_v  = cfg.unstable_limit;
        if (act == ActTick) begin
            // count the timers down, holding at zero
            if (rate_t != 0) rate_t = rate_t - 16'd1;
            if (settle_t != 0) settle_t = settle_t - 16'd1;
            if (enter_t != 0) enter_t = enter_t - 16'd1;
        end else begin
            // grow the shift when the rate timer has run out
            if (rate_t == 0) begin
                rate_t = cfg.rate_reload;
                if (shf_q < cfg.shift_max) shf_q = shf_q + 4'd1;
            end
            // move the accumulator by the difference, floor-shifted
            diff  = $signed({10'b0, smp, 8'h00}) - $signed({2'b0, acc_q});
            step  = diff >>> shf_q;
            acc_q = acc_q + step[31:0];
            if (step >= 256) begin
                settle_t = cfg.settle_reload;
                move = 1;
            end else if (step < -256) begin
                settle_t = cfg.settle_reload;
                move = -1;
            end
            if (stb_q) begin
                // track the run away from the stable reference
                offset_v = $signed({2'b0, acc_q}) - $signed({2'b0, ref_q});
                neg  = offset_v < 0;
                near = neg ? (offset_v >= -256) : (offset_v <= 255);
                ramp_q = neg ? ramp_q - 8'd1 : ramp_q + 8'd1;
                ramp_v = $signed(ramp_q);
                if (near || (neg != (ramp_v < 0))) begin
                    ramp_q = '0;
                end else if (ramp_v > leave_v || ramp_v < -leave_v) begin
                    ramp_q  = '0;
                    shf_q   = '0;
                    stb_q   = 1'b0;
                    rate_t  = cfg.rate_reload;
                    enter_t = cfg.enter_delay;
                end
            end else begin
                settle_t = cfg.settle_reload;
                if (move != 0) begin
                    // count steps in one direction, drop the shift on a long run
                    ramp_q  = (move > 0) ? ramp_q + 8'd1 : ramp_q - 8'd1;
                    enter_t = cfg.enter_delay;
                    ramp_v  = $signed(ramp_q);
                    if ((ramp_v < 0) != (move < 0)) begin
                        ramp_q = '0;
                        ramp_v = 0;
                    end
                    if (ramp_v > unst_v || ramp_v < -unst_v) begin
                        ramp_q = '0;
                        shf_q  = '0;
                        rate_t = cfg.rate_reload;
                    end
                end else begin
                    ramp_q = '0;
                    if (enter_t == 0) begin
                        stb_q = 1'b1;
                        ref_q = acc_q;
                    end
                end
            end
        end
        res.filtered    = acc_q[23:0];
        res.is_stable   = stb_q;
        res.direction   = 2'(move);
        res.shift_now   = shf_q;
        res.settle_left = settle_t;
    endtask

    always @(posedge i_clk) begin
        weigh_res_t want;
        weigh_res_t got;
        if (!i_rst_n) begin
            clear_filter_model();
            expected_q.delete();
        end else begin
            // compare the result transaction with the oldest prediction
            if (o_out_valid && !i_out_stall) begin
                got = {o_filtered, o_is_stable, o_direction, o_shift_now, o_settle_left};
                results_cnt++;
                if (got.is_stable === 1'b1) stable_cnt++;
                if (got.direction != 2'b00) move_cnt++;
                if (expected_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", {8'b0, got.filtered}, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.filtered !== want.filtered)
                        flag_mismatch("filtered", {8'b0, got.filtered}, {8'b0, want.filtered});
                    if (got.is_stable !== want.is_stable)
                        flag_mismatch("is_stable", {31'b0, got.is_stable},
                                      {31'b0, want.is_stable});
                    if (got.direction !== want.direction)
                        flag_mismatch("direction", {30'b0, got.direction},
                                      {30'b0, want.direction});
                    if (got.shift_now !== want.shift_now)
                        flag_mismatch("shift_now", {28'b0, got.shift_now},
                                      {28'b0, want.shift_now});
                    if (got.settle_left !== want.settle_left)
                        flag_mismatch("settle_left", {16'b0, got.settle_left},
                                      {16'b0, want.settle_left});
                end
            end
            // predict every accepted input transaction
            if (i_in_valid && !o_in_stall) begin
                predict_weigh(action_e'(i_action), i_sample, want);
                expected_q.push_back(want);
            end
            // follow register writes, check read-back
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[4:2])
                        RegRateReload:    cfg.rate_reload    = pwdata[15:0];
                        RegShiftMax:      cfg.shift_max      = pwdata[3:0];
                        RegLeaveLimit:    cfg.leave_limit    = pwdata[6:0];
                        RegUnstableLimit: cfg.unstable_limit = pwdata[6:0];
                        RegEnterDelay:    cfg.enter_delay    = pwdata[15:0];
                        RegSettleReload:  cfg.settle_reload  = pwdata[15:0];
                        default: ;
                    endcase
                end else if (prdata !== cfg_readback(paddr[4:2])) begin
                    flag_mismatch("register read-back", prdata, cfg_readback(paddr[4:2]));
                end
            end
        end
        n_pending    <= expected_q.size();
        n_fail       <= fail_cnt;
        n_results    <= results_cnt;
        n_stable_out <= stable_cnt;
        n_moves      <= move_cnt;
    end

endmodule

### tb/sv/adaptive_weight_filter_with_stability_tb.sv
// Testbench top of the adaptive weight filter: clock, reset, stimulus, back-pressure and verdict.
module adaptive_weight_filter_with_stability_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import awfs_pkg::*;
    import awfs_tb_pkg::*;

    localparam int ItemsTarget = 1650;
    localparam int HoldCycles  = 60;
    localparam int StallLimit  = 2000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_action = 1'b0;
    logic [15:0]         i_sample = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [23:0]         o_filtered;
    logic                o_is_stable;
    logic signed [1:0]   o_direction;
    logic [3:0]          o_shift_now;
    logic [15:0]         o_settle_left;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrW-1:0]    paddr = '0;
    logic [DataW-1:0]    pwdata = '0;
    logic [DataW-1:0]    prdata;
    logic                pready;

    int n_fail;
    int n_pending;
    int n_results;
    int n_stable_out;
    int n_moves;

    int n_sent = 0;
    int n_ticks = 0;
    int n_writes = 0;
    int hold_req = 0;
    int idle_cycles = 0;
    bit idle_on = 1'b0;

    // Opening sequence: timers at zero, field extremes, both transaction kinds
    logic [16:0] opening [24] = '{
        {ActTick, 16'h0000},   {ActSample, 16'h0000}, {ActSample, 16'hFFFF},
        {ActSample, 16'hFFFF}, {ActSample, 16'hFFFF}, {ActTick, 16'hFFFF},
        {ActTick, 16'h1234},   {ActSample, 16'h0000}, {ActSample, 16'h0000},
        {ActSample, 16'h8000}, {ActSample, 16'h0001}, {ActSample, 16'hFFFE},
        {ActSample, 16'h00FF}, {ActSample, 16'hFF00}, {ActSample, 16'h5555},
        {ActSample, 16'hAAAA}, {ActSample, 16'h7FFF}, {ActTick, 16'h0000},
        {ActSample, 16'h8000}, {ActSample, 16'h8000}, {ActSample, 16'h8000},
        {ActSample, 16'h8000}, {ActTick, 16'h0000},   {ActSample, 16'h8001}
    };

    adaptive_weight_filter_with_stability uut (.*);

    awfs_checker checker_i (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) < 85) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Zero or full scale now and then, otherwise a typical small value
    function automatic int pick_setting(input int full, input int typical);
        case ($urandom_range(9))
            0:       return 0;
            1:       return full;
            default: return $urandom_range(typical);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic push_item(input action_e act, input logic [15:0] smp);
        if (idle_on && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_sample   <= smp;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (act == ActTick) n_ticks++;
    endtask

    task automatic push_tick();
        push_item(ActTick, 16'($urandom));
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all registers while idle, upper data bits random, then read them back
    task automatic configure_filter(input logic [15:0] rr, input logic [3:0] sm,
                                    input logic [6:0] ll, input logic [6:0] ul,
                                    input logic [15:0] ed, input logic [15:0] sr);
        wait_drain();
        apb_access(1'b1, RegRateReload,    {16'($urandom), rr});
        apb_access(1'b1, RegShiftMax,      {28'($urandom), sm});
        apb_access(1'b1, RegLeaveLimit,    {25'($urandom), ll});
        apb_access(1'b1, RegUnstableLimit, {25'($urandom), ul});
        apb_access(1'b1, RegEnterDelay,    {16'($urandom), ed});
        apb_access(1'b1, RegSettleReload,  {16'($urandom), sr});
        n_writes += 6;
        for (int r = RegRateReload; r <= RegSettleReload; r++)
            apb_access(1'b0, 3'(r), 32'($urandom));
    endtask

    // Load-cell traffic: settling runs around a weight with noise and ticks, some random bursts
    task automatic weigh_traffic(input int count);
        int target;
        int w;
        int amp;
        int tick_pct;
        int len;
        int v;
        target = n_sent + count;
        while (n_sent < target) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(5, 1))
                    push_item(action_e'($urandom_range(1)), 16'($urandom));
            end else begin
                case ($urandom_range(7))
                    0:       w = 0;
                    1:       w = 65535;
                    default: w = $urandom_range(65535);
                endcase
                case ($urandom_range(3))
                    0:       amp = 0;
                    1:       amp = 2;
                    2:       amp = 40;
                    default: amp = 1000;
                endcase
                tick_pct = $urandom_range(60);
                len = $urandom_range(40, 5);
                repeat (len) begin
                    if ($urandom_range(99) < tick_pct) begin
                        push_tick();
                    end else begin
                        v = w - amp + int'($urandom_range(2 * amp));
                        if (v < 0) v = 0;
                        else if (v > 65535) v = 65535;
                        push_item(ActSample, 16'(v));
                    end
                end
            end
            if ($urandom_range(19) == 0) wait_drain();
        end
    endtask

    // Output back-pressure: short random stalls, a long hold on request
    initial begin : sink
        int hold_seen;
        int n;
        bit stall_v;
        hold_seen = 0;
        @(posedge i_clk);
        forever begin
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                stall_v = 1'b1;
                n = HoldCycles;
            end else if (!idle_on || $urandom_range(99) < 70) begin
                stall_v = 1'b0;
                n = $urandom_range(4, 1);
            end else begin
                stall_v = 1'b1;
                n = pick_gap();
            end
            i_out_stall <= stall_v;
            repeat (n) @(posedge i_clk);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == StallLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int w;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opening transactions at reset settings
        foreach (opening[i]) push_item(action_e'(opening[i][16]), opening[i][15:0]);

        // full-scale settings, sender streaming against a long output hold
        idle_on = 1'b1;
        configure_filter(16'hFFFF, 4'hF, 7'h7F, 7'h7F, 16'hFFFF, 16'hFFFF);
        idle_on = 1'b0;
        hold_req++;
        weigh_traffic(100);

        // all settings zero
        idle_on = 1'b1;
        configure_filter(16'h0000, 4'h0, 7'h00, 7'h00, 16'h0000, 16'h0000);
        weigh_traffic(100);

        // settle, turn stable, then creep away long enough to wrap the ramp counter
        configure_filter(16'd0, 4'd4, 7'd127, 7'd127, 16'd2, 16'd100);
        w = 30000;
        repeat (150) push_item(ActSample, 16'(w));
        repeat (3) push_tick();
        repeat (2) push_item(ActSample, 16'(w));
        repeat (140) push_item(ActSample, 16'(w + 20));

        // drop out of stable at once, then a long rise while unstable
        configure_filter(16'd0, 4'd8, 7'd0, 7'd127, 16'hFFFF, 16'd100);
        push_item(ActSample, 16'h0000);
        repeat (150) push_item(ActSample, 16'hFFFF);

        // shift now above the new maximum
        configure_filter(16'd0, 4'd2, 7'd30, 7'd127, 16'd10, 16'd50);
        weigh_traffic(60);

        // random settings
        while (n_sent < ItemsTarget) begin
            configure_filter(16'(pick_setting(65535, 15)), 4'(pick_setting(15, 15)),
                             7'(pick_setting(127, 40)), 7'(pick_setting(127, 15)),
                             16'(pick_setting(65535, 30)), 16'(pick_setting(65535, 400)));
            idle_on = ($urandom_range(9) < 7);
            if ($urandom_range(3) == 0) hold_req++;
            weigh_traffic($urandom_range(180, 100));
        end

        wait_drain();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d transactions (%0d ticks) across %0d register writes.",
                 n_sent, n_ticks, n_writes);
        $display("Checked %0d results: %0d while stable, %0d with a full-count step.",
                 n_results, n_stable_out, n_moves);
        if (n_fail == 0 && n_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/awfs_pkg.sv
hw/rtl/awfs_cfg.sv
hw/rtl/adaptive_weight_filter_with_stability.sv
tb/sv/awfs_tb_pkg.sv
tb/sv/awfs_checker.sv
tb/sv/adaptive_weight_filter_with_stability_tb.sv
